/* hw/rtl/ps2hse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hse_pkg
// Shared widths, item and result types, and codes for the PS/2 host engine.
// ----------------------------------------------------------------------------
package ps2hse_pkg;

    localparam int BYTE_W         = 8;
    localparam int FUNC_W         = 2;
    localparam int ERR_W          = 3;
    localparam int FIFO_DEPTH_DEF = 256;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 32;

    // event kinds carried on s_tuser
    localparam logic [FUNC_W-1:0] FN_EDGE   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_ENABLE = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_START  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_PARITY = 3'd2;
    localparam logic [ERR_W-1:0] ERR_STOP   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_ACK    = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BUSY   = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              data_line;
        logic              clock_line;
        logic [BYTE_W-1:0] write_byte;
        logic              flush_first;
    } item_t;

    typedef struct packed {
        logic              data_release;
        logic              edge_mode;
        logic              busy_res;
        logic              ok;
        logic [ERR_W-1:0]  error_code;
        logic              write_accepted;
        logic              rx_valid;
        logic [BYTE_W-1:0] bytes_available;
    } res_t;

endpackage

/* hw/rtl/ps2hse_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hse_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ps2hse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ps2hse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hse_core
// Frame state machine, receive FIFO pointers and FIFO storage.
// ----------------------------------------------------------------------------
module ps2hse_core #(
    parameter int FIFO_DEPTH = ps2hse_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  ps2hse_pkg::item_t           item,
    output ps2hse_pkg::res_t            res,
    output logic [ps2hse_pkg::BYTE_W-1:0] rx_q
);
    import ps2hse_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    localparam logic [3:0] PH_ERROR     = 4'd0;
    localparam logic [3:0] PH_IDLE      = 4'd1;
    localparam logic [3:0] PH_RX_DATA   = 4'd2;
    localparam logic [3:0] PH_RX_PARITY = 4'd3;
    localparam logic [3:0] PH_RX_STOP   = 4'd4;
    localparam logic [3:0] PH_TX_BEGIN  = 4'd5;
    localparam logic [3:0] PH_TX_DATA   = 4'd6;
    localparam logic [3:0] PH_TX_PARITY = 4'd7;
    localparam logic [3:0] PH_TX_STOP   = 4'd8;
    localparam logic [3:0] PH_TX_ACK    = 4'd9;
    localparam logic [3:0] PH_END       = 4'd10;

    localparam logic [3:0] BITS_FULL = 4'd8;

    logic [3:0]        phase_reg, phase_next;
    logic [3:0]        bits_reg, bits_next;
    logic              par_reg, par_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic              edge_sel_reg, edge_sel_next;
    logic              drive_reg, drive_next;

    logic [3:0]        bits_dec;
    logic [AW-1:0]     head_inc, tail_inc;
    logic              wr_ok, pop_ok, push;
    logic [AW:0]       tail_w, head_w, depth_w;

    assign bits_dec = bits_reg - 4'd1;
    assign head_inc = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        par_next      = par_reg;
        shift_next    = shift_reg;
        err_next      = err_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        edge_sel_next = edge_sel_reg;
        drive_next    = drive_reg;
        wr_ok         = 1'b0;
        pop_ok        = 1'b0;
        push          = 1'b0;

        case (item.func)
            FN_EDGE:
            begin
                unique case (phase_reg) inside
                    PH_END:
                    begin
                        edge_sel_next = 1'b0;
                        if (item.data_line || item.clock_line)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // start bit seen while still watching both edges
                            phase_next = PH_RX_DATA;
                            shift_next = '0;
                            par_next   = 1'b0;
                            bits_next  = BITS_FULL;
                        end
                    end
                    PH_IDLE:
                    begin
                        if (!item.data_line)
                        begin
                            phase_next = PH_RX_DATA;
                            shift_next = '0;
                            par_next   = 1'b0;
                            bits_next  = BITS_FULL;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_START;
                        end
                    end
                    PH_RX_DATA:
                    begin
                        par_next   = par_reg ^ item.data_line;
                        shift_next = {item.data_line, shift_reg[BYTE_W-1:1]};
                        bits_next  = bits_dec;
                        if (bits_dec == 4'd0)
                        begin
                            phase_next = PH_RX_PARITY;
                        end
                    end
                    PH_RX_PARITY:
                    begin
                        par_next = par_reg ^ item.data_line;
                        if (par_reg ^ item.data_line)
                        begin
                            phase_next = PH_RX_STOP;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_PARITY;
                        end
                    end
                    PH_RX_STOP:
                    begin
                        edge_sel_next = 1'b1;
                        if (item.data_line)
                        begin
                            phase_next = PH_END;
                            // full FIFO drops the byte
                            if (tail_inc != head_reg)
                            begin
                                push      = 1'b1;
                                tail_next = tail_inc;
                            end
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_STOP;
                        end
                    end
                    PH_TX_BEGIN, PH_TX_DATA:
                    begin
                        drive_next = shift_reg[0];
                        par_next   = par_reg ^ shift_reg[0];
                        shift_next = {1'b0, shift_reg[BYTE_W-1:1]};
                        bits_next  = bits_dec;
                        phase_next = (bits_dec == 4'd0) ? PH_TX_PARITY : PH_TX_DATA;
                    end
                    PH_TX_PARITY:
                    begin
                        drive_next = ~par_reg;
                        phase_next = PH_TX_STOP;
                    end
                    PH_TX_STOP:
                    begin
                        drive_next = 1'b1;
                        phase_next = PH_TX_ACK;
                    end
                    PH_TX_ACK:
                    begin
                        if (!item.data_line)
                        begin
                            phase_next    = PH_END;
                            edge_sel_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_ACK;
                        end
                    end
                    default:
                    begin
                        // error phase and unused codes ignore edges
                    end
                endcase
            end
            FN_WRITE:
            begin
                if (phase_reg == PH_ERROR)
                begin
                    // refused silently
                end
                else if (phase_reg > PH_IDLE)
                begin
                    err_next = ERR_BUSY;
                end
                else
                begin
                    wr_ok         = 1'b1;
                    drive_next    = 1'b0;
                    err_next      = ERR_NONE;
                    phase_next    = PH_TX_BEGIN;
                    shift_next    = item.write_byte;
                    par_next      = 1'b0;
                    bits_next     = BITS_FULL;
                    edge_sel_next = 1'b0;
                    if (item.flush_first)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            FN_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    pop_ok    = 1'b1;
                    head_next = head_inc;
                end
            end
            FN_ENABLE:
            begin
                drive_next    = 1'b1;
                head_next     = '0;
                tail_next     = '0;
                err_next      = ERR_NONE;
                phase_next    = PH_IDLE;
                edge_sel_next = 1'b0;
            end
        endcase
    end

    assign tail_w  = (AW + 1)'(tail_next);
    assign head_w  = (AW + 1)'(head_next);
    assign depth_w = (AW + 1)'(FIFO_DEPTH);

    always_comb
    begin
        res.data_release   = drive_next;
        res.edge_mode      = edge_sel_next;
        res.busy_res       = (phase_next > PH_IDLE);
        res.ok             = (phase_next != PH_ERROR);
        res.error_code     = err_next;
        res.write_accepted = wr_ok;
        res.rx_valid       = pop_ok;
        if (tail_w >= head_w)
        begin
            res.bytes_available = BYTE_W'(tail_w - head_w);
        end
        else
        begin
            res.bytes_available = BYTE_W'(depth_w + tail_w - head_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ERROR;
            bits_reg     <= '0;
            par_reg      <= 1'b0;
            shift_reg    <= '0;
            err_reg      <= ERR_NONE;
            head_reg     <= '0;
            tail_reg     <= '0;
            edge_sel_reg <= 1'b0;
            drive_reg    <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            bits_reg     <= bits_next;
            par_reg      <= par_next;
            shift_reg    <= shift_next;
            err_reg      <= err_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            edge_sel_reg <= edge_sel_next;
            drive_reg    <= drive_next;
        end
    end

    ps2hse_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (step && push),
        .waddr (tail_reg),
        .wdata (shift_reg),
        .re    (step && pop_ok),
        .raddr (head_reg),
        .rdata (rx_q)
    );

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(head_reg) < FIFO_DEPTH) && (32'(tail_reg) < FIFO_DEPTH))
        else $error("FIFO pointer out of range");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= BITS_FULL)
        else $error("bit counter above eight");

    a_write_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && wr_ok |=> (phase_reg == PH_TX_BEGIN) && !drive_reg)
        else $error("accepted write did not start a transmit frame");

    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_ERROR) && (item.func != FN_ENABLE)
        |=> phase_reg == PH_ERROR)
        else $error("error phase left without enable");

endmodule

/* hw/rtl/ps2_host_serial_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_host_serial_engine
// PS/2 host engine: frame receive and transmit with a receive byte FIFO.
// ----------------------------------------------------------------------------
// Each event (clock edge, write request, pop, enable) is one transfer on the
// slave side and yields exactly one result transfer on the master side. The
// engine takes one event per clock while the result sink keeps up: an event
// is held in the input register, the state machine steps on it when the
// result slot is free or being drained, and the result register loads on
// that step; a stalled result sink holds s_tready low. Popped
// bytes come from a simple dual-port RAM of FIFO_DEPTH entries whose
// registered read lands together with the rest of the result; the FIFO holds
// up to FIFO_DEPTH - 1 bytes and needs no clearing pass after reset. The
// engine leaves reset in its error state and waits for an enable event.
module ps2_host_serial_engine #(
    parameter int FIFO_DEPTH = ps2hse_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] data_line, [1] clock_line, [9:2] write_byte, [10] flush_first
    input  logic [ps2hse_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [ps2hse_pkg::FUNC_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] data_release, [1] edge_mode, [2] busy_res, [3] ok, [6:4] error_code,
    // [7] write_accepted, [8] rx_valid, [16:9] rx_byte, [24:17] bytes_available
    output logic [ps2hse_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ps2hse_pkg::*;

    logic        in_v_reg;
    item_t       in_reg;
    logic        out_v_reg;
    res_t        res_reg;
    res_t        res_comb;
    logic [BYTE_W-1:0] rx_q;
    logic        adv;

    // step the engine when the result slot is free or being drained
    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_v_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.func        <= s_tuser;
            in_reg.data_line   <= s_tdata[0];
            in_reg.clock_line  <= s_tdata[1];
            in_reg.write_byte  <= s_tdata[9:2];
            in_reg.flush_first <= s_tdata[10];
        end
        if (adv)
        begin
            res_reg <= res_comb;
        end
    end

    ps2hse_core #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (adv),
        .item  (in_reg),
        .res   (res_comb),
        .rx_q  (rx_q)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0,
                       res_reg.bytes_available,
                       res_reg.rx_valid ? rx_q : BYTE_W'(0),
                       res_reg.rx_valid,
                       res_reg.write_accepted,
                       res_reg.error_code,
                       res_reg.ok,
                       res_reg.busy_res,
                       res_reg.edge_mode,
                       res_reg.data_release};

endmodule

/* verif/ps2hse_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2hse_tb_pkg
// Scoreboard for the PS/2 host engine: an untimed model of the engine works
// out the status word of every accepted event and checks the DUT results.
// ----------------------------------------------------------------------------
package ps2hse_tb_pkg;

    import ps2hse_pkg::*;

    typedef enum logic [3:0] {
        PH_DOWN,
        PH_IDLE,
        PH_RX_DATA,
        PH_RX_PARITY,
        PH_RX_STOP,
        PH_TX_BEGIN,
        PH_TX_DATA,
        PH_TX_PARITY,
        PH_TX_STOP,
        PH_TX_ACK,
        PH_END
    } link_phase_e;

    typedef struct packed {
        logic              data_release;
        logic              edge_mode;
        logic              busy;
        logic              ok;
        logic [ERR_W-1:0]  error_code;
        logic              write_accepted;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] bytes_available;
    } link_status_t;

    class ps2_link_scoreboard;

        link_phase_e       phase;
        logic [3:0]        bits_left;
        logic              parity;
        logic [BYTE_W-1:0] shreg;
        logic [ERR_W-1:0]  last_err;
        logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH_DEF];
        int                head;
        int                tail;
        logic              both_edges;
        logic              line_release;
        link_status_t      status_q[$];

        int mismatches;
        int results_checked;
        int bytes_queued;
        int bytes_dropped;
        int bytes_popped;
        int writes_started;
        int error_entries;

        function new();
            phase        = PH_DOWN;
            bits_left    = '0;
            parity       = 1'b0;
            shreg        = '0;
            last_err     = ERR_NONE;
            head         = 0;
            tail         = 0;
            both_edges   = 1'b0;
            line_release = 1'b1;
            foreach (rx_mem[i])
                rx_mem[i] = '0;
            mismatches      = 0;
            results_checked = 0;
            bytes_queued    = 0;
            bytes_dropped   = 0;
            bytes_popped    = 0;
            writes_started  = 0;
            error_entries   = 0;
        endfunction

        function void enter_error(logic [ERR_W-1:0] code);
            phase    = PH_DOWN;
            last_err = code;
            error_entries++;
        endfunction

        function void begin_rx();
            phase     = PH_RX_DATA;
            shreg     = '0;
            parity    = 1'b0;
            bits_left = 4'd8;
        endfunction

        function void clock_step(logic bit_in, logic clk_in);
            case (phase) inside
                PH_END:
                begin
                    both_edges = 1'b0;
                    // low data with low clock is a fresh start bit
                    if (bit_in || clk_in)
                        phase = PH_IDLE;
                    else
                        begin_rx();
                end
                PH_IDLE:
                begin
                    if (!bit_in)
                        begin_rx();
                    else
                        enter_error(ERR_START);
                end
                PH_RX_DATA:
                begin
                    parity    = parity ^ bit_in;
                    shreg     = {bit_in, shreg[BYTE_W-1:1]};
                    bits_left = bits_left - 4'd1;
                    if (bits_left == 4'd0)
                        phase = PH_RX_PARITY;
                end
                PH_RX_PARITY:
                begin
                    parity = parity ^ bit_in;
                    if (parity)
                        phase = PH_RX_STOP;
                    else
                        enter_error(ERR_PARITY);
                end
                PH_RX_STOP:
                begin
                    phase      = PH_END;
                    both_edges = 1'b1;
                    if (bit_in)
                    begin
                        if ((tail + 1) % FIFO_DEPTH_DEF != head)
                        begin
                            rx_mem[tail] = shreg;
                            tail = (tail + 1) % FIFO_DEPTH_DEF;
                            bytes_queued++;
                        end
                        else
                        begin
                            bytes_dropped++;
                        end
                    end
                    else
                    begin
                        // edge mode is left at both edges
                        enter_error(ERR_STOP);
                    end
                end
                PH_TX_BEGIN, PH_TX_DATA:
                begin
                    phase        = PH_TX_DATA;
                    line_release = shreg[0];
                    parity       = parity ^ shreg[0];
                    shreg        = shreg >> 1;
                    bits_left    = bits_left - 4'd1;
                    if (bits_left == 4'd0)
                        phase = PH_TX_PARITY;
                end
                PH_TX_PARITY:
                begin
                    line_release = ~parity;
                    phase        = PH_TX_STOP;
                end
                PH_TX_STOP:
                begin
                    line_release = 1'b1;
                    phase        = PH_TX_ACK;
                end
                PH_TX_ACK:
                begin
                    if (!bit_in)
                    begin
                        phase      = PH_END;
                        both_edges = 1'b1;
                    end
                    else
                    begin
                        enter_error(ERR_ACK);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_item(item_t it);
            link_status_t s;
            s = '0;
            case (it.func)
                FN_EDGE:
                    clock_step(it.data_line, it.clock_line);
                FN_WRITE:
                begin
                    // refused without a trace in the error phase
                    if (phase != PH_DOWN)
                    begin
                        if (phase != PH_IDLE)
                        begin
                            last_err = ERR_BUSY;
                        end
                        else
                        begin
                            line_release = 1'b0;
                            last_err     = ERR_NONE;
                            phase        = PH_TX_BEGIN;
                            shreg        = it.write_byte;
                            parity       = 1'b0;
                            bits_left    = 4'd8;
                            if (it.flush_first)
                            begin
                                head = 0;
                                tail = 0;
                            end
                            both_edges       = 1'b0;
                            s.write_accepted = 1'b1;
                            writes_started++;
                        end
                    end
                end
                FN_POP:
                begin
                    if (head != tail)
                    begin
                        s.rx_valid = 1'b1;
                        s.rx_byte  = rx_mem[head];
                        head = (head + 1) % FIFO_DEPTH_DEF;
                        bytes_popped++;
                    end
                end
                default:
                begin
                    line_release = 1'b1;
                    head         = 0;
                    tail         = 0;
                    last_err     = ERR_NONE;
                    phase        = PH_IDLE;
                    both_edges   = 1'b0;
                end
            endcase
            s.data_release    = line_release;
            s.edge_mode       = both_edges;
            s.busy            = (phase != PH_DOWN) && (phase != PH_IDLE);
            s.ok              = (phase != PH_DOWN);
            s.error_code      = last_err;
            s.bytes_available = BYTE_W'((FIFO_DEPTH_DEF + tail - head) % FIFO_DEPTH_DEF);
            status_q.push_back(s);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_checked, what, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] word);
            link_status_t want;
            results_checked++;
            if (status_q.size() == 0)
            begin
                report_mismatch("result with no event pending", word, '0);
                return;
            end
            want = status_q.pop_front();
            if (word[0] !== want.data_release)
                report_mismatch("data_release", word[0], want.data_release);
            if (word[1] !== want.edge_mode)
                report_mismatch("edge_mode", word[1], want.edge_mode);
            if (word[2] !== want.busy)
                report_mismatch("busy_res", word[2], want.busy);
            if (word[3] !== want.ok)
                report_mismatch("ok", word[3], want.ok);
            if (word[6:4] !== want.error_code)
                report_mismatch("error_code", word[6:4], want.error_code);
            if (word[7] !== want.write_accepted)
                report_mismatch("write_accepted", word[7], want.write_accepted);
            if (word[8] !== want.rx_valid)
                report_mismatch("rx_valid", word[8], want.rx_valid);
            if (word[16:9] !== want.rx_byte)
                report_mismatch("rx_byte", word[16:9], want.rx_byte);
            if (word[24:17] !== want.bytes_available)
                report_mismatch("bytes_available", word[24:17], want.bytes_available);
        endtask

    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the PS/2 host engine: directed frames, a receive FIFO
// fill and drain pass, and random frame traffic under bursty input and a
// stalling result sink, every result checked against the scoreboard model.
// ----------------------------------------------------------------------------
module tb_top;

    import ps2hse_pkg::*;
    import ps2hse_tb_pkg::*;

    localparam int FAULT_NONE   = 0;
    localparam int FAULT_PARITY = 1;
    localparam int FAULT_STOP   = 2;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_MARGIN = 8;

    // what the stimulus believes the engine is doing between sequences
    typedef enum logic [1:0] {BUS_IDLE, BUS_END, BUS_DOWN} bus_view_e;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]      s_tuser  = FN_EDGE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    ps2_link_scoreboard sb;
    bus_view_e          view          = BUS_DOWN;
    int                 items_sent    = 0;
    int                 burst_left    = 0;
    int                 hold_requests = 0;

    ps2_host_serial_engine #(
        .FIFO_DEPTH(FIFO_DEPTH_DEF)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(item_t'{func:        s_tuser,
                                     data_line:   s_tdata[0],
                                     clock_line:  s_tdata[1],
                                     write_byte:  s_tdata[9:2],
                                     flush_first: s_tdata[10]});
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // result sink: changing stall patterns, plus long hold-offs on request
    initial
    begin : sink
        int mode;
        int span;
        int cyc;
        int hold_done;
        mode      = 0;
        span      = 0;
        cyc       = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_done < hold_requests)
            begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
            end
            span--;
            cyc++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom);
                2:       m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ((cyc % 7) >= 3);
            endcase
        end
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic item_t rand_filler(logic [FUNC_W-1:0] fn);
        item_t it;
        it.func        = fn;
        it.data_line   = 1'($urandom);
        it.clock_line  = 1'($urandom);
        it.write_byte  = 8'($urandom);
        it.flush_first = 1'($urandom);
        return it;
    endfunction

    // bursts of back-to-back transfers separated by random gaps
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {{(IN_TDATA_W - 11){1'b0}}, it.flush_first, it.write_byte,
                     it.clock_line, it.data_line};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_edge(input logic dl, input logic cl);
        item_t it;
        it = rand_filler(FN_EDGE);
        it.data_line  = dl;
        it.clock_line = cl;
        send_item(it);
    endtask

    task automatic put_write(input logic [BYTE_W-1:0] b, input logic fl);
        item_t it;
        it = rand_filler(FN_WRITE);
        it.write_byte  = b;
        it.flush_first = fl;
        send_item(it);
    endtask

    task automatic put_pop();
        send_item(rand_filler(FN_POP));
    endtask

    task automatic put_enable();
        send_item(rand_filler(FN_ENABLE));
        view = BUS_IDLE;
    endtask

    // leave the end phase: high data or high clock returns to idle
    task automatic release_bus();
        if ($urandom_range(0, 1))
            put_edge(1'b1, 1'($urandom));
        else
            put_edge(1'b0, 1'b1);
        view = BUS_IDLE;
    endtask

    task automatic bring_to_idle();
        if (view == BUS_DOWN)
            put_enable();
        else if (view == BUS_END)
            release_bus();
    endtask

    // a write or a pop slipped into the middle of a frame
    task automatic intrude();
        if ($urandom_range(0, 1))
            put_write(8'($urandom), 1'($urandom));
        else
            put_pop();
    endtask

    task automatic recv_frame(input logic [BYTE_W-1:0] b, input int fault, input bit quiet);
        int k;
        if (view == BUS_DOWN)
            put_enable();
        // from the end phase the start bit needs the clock low as well
        put_edge(1'b0, (view == BUS_END) ? 1'b0 : 1'($urandom));
        for (k = 0; k < BYTE_W; k++)
        begin
            if (!quiet && $urandom_range(0, 19) == 0)
                intrude();
            put_edge(b[k], 1'($urandom));
        end
        put_edge((~^b) ^ (fault == FAULT_PARITY), 1'($urandom));
        if (fault == FAULT_PARITY)
        begin
            view = BUS_DOWN;
            return;
        end
        put_edge(fault != FAULT_STOP, 1'($urandom));
        view = (fault == FAULT_STOP) ? BUS_DOWN : BUS_END;
    endtask

    task automatic xmit_frame(input logic [BYTE_W-1:0] b, input logic fl, input bit bad_ack);
        int k;
        bring_to_idle();
        put_write(b, fl);
        // eight data bits, parity, stop, then the device acknowledge
        for (k = 0; k < 11; k++)
        begin
            if (k < 10 && $urandom_range(0, 19) == 0)
                intrude();
            put_edge((k == 10) ? logic'(bad_ack) : 1'($urandom), 1'($urandom));
        end
        view = bad_ack ? BUS_DOWN : BUS_END;
    endtask

    task automatic bad_start();
        bring_to_idle();
        put_edge(1'b1, 1'($urandom));
        view = BUS_DOWN;
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                recv_frame(8'($urandom),
                           (r < 3) ? FAULT_PARITY : ((r < 6) ? FAULT_STOP : FAULT_NONE),
                           1'b0);
            else if (r < 68)
                xmit_frame(8'($urandom), ($urandom_range(0, 3) == 0), (r < 52));
            else if (r < 78)
                repeat ($urandom_range(1, 4)) put_pop();
            else if (r < 82)
                bad_start();
            else if (r < 86)
            begin
                repeat ($urandom_range(1, 6)) send_item(rand_filler(2'($urandom)));
                put_enable();
            end
            else if (r < 94)
            begin
                if (view == BUS_END)
                    release_bus();
                else
                    put_pop();
            end
            else
            begin
                put_enable();
            end
        end
    endtask

    // queue a run of bytes, pop part of them, queue more, then pop past empty
    task automatic fifo_fill_pass();
        int k;
        put_enable();
        for (k = 0; k < 30; k++)
            recv_frame(8'($urandom), FAULT_NONE, 1'b1);
        hold_requests++;
        repeat (20) put_pop();
        for (k = 0; k < 10; k++)
            recv_frame(8'($urandom), FAULT_NONE, 1'b1);
        repeat (30) put_pop();
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // error phase after reset: edges ignored, writes refused
        put_edge(1'b0, 1'b0);
        put_write(8'hA5, 1'b1);
        put_pop();
        put_enable();
        bad_start();
        recv_frame(8'hFF, FAULT_NONE, 1'b1);
        // end phase still counts as busy
        put_write(8'h00, 1'b0);
        // start bit taken straight from the end phase, then a bad stop bit
        recv_frame(8'h80, FAULT_STOP, 1'b1);
        wait_drained();

        hold_requests++;
        run_random(400);
        wait_drained();

        fifo_fill_pass();
        wait_drained();

        run_random(400);
        wait_drained();
        repeat (DRAIN_MARGIN) @(posedge clk);

        $display("Covered %0d events and %0d checked results: %0d writes started, %0d errors",
                 items_sent, sb.results_checked, sb.writes_started, sb.error_entries);
        $display("Receive FIFO: %0d bytes queued, %0d dropped while full, %0d popped",
                 sb.bytes_queued, sb.bytes_dropped, sb.bytes_popped);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* ps2_host_serial_engine.f */
hw/rtl/ps2hse_pkg.sv
hw/rtl/ps2hse_ram.sv
hw/rtl/ps2hse_core.sv
hw/rtl/ps2_host_serial_engine.sv
verif/ps2hse_tb_pkg.sv
verif/tb_top.sv
